// File: src/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg: shared types for the chained hash map engine
// operation codes and the command and status words between controller and
// datapath
// ----------------------------------------------------------------------------
package chm_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic clr_step;   // one step of the clearing pass
      logic accept;     // request word taken this cycle
      logic head_rd;    // read bucket head and free stack top
      logic head_chk;   // bucket head data is back
      logic node_chk;   // node data is back
      logic finish;     // apply updates and load the response
   } chm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic op_valid;
      logic head_valid;
      logic key_match;
      logic link_valid;
      logic out_free;
   } chm_stat_type;

endpackage

// File: src/chm_if.sv
// ----------------------------------------------------------------------------
// chm_req_if / chm_rsp_if: valid-ready channels of the hash map engine
// a word moves on a rising edge with valid and ready both high
// ----------------------------------------------------------------------------
interface chm_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic signed [31:0] key;
   logic [31:0]       value;

   modport source (output valid, output operation, output key, output value, input ready);
   modport sink (input valid, input operation, input key, input value, output ready);
endinterface

interface chm_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] value_out;
   logic        status;

   modport source (output valid, output found, output value_out, output status, input ready);
   modport sink (input valid, input found, input value_out, input status, output ready);
endinterface

// File: src/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl: request sequencer
// clearing pass, bucket head read, chain walk and final update
// ----------------------------------------------------------------------------
module chm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  chm_pkg::chm_stat_type stat,
   output chm_pkg::chm_cmd_type  cmd,
   output logic                 req_ready
);
   import chm_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HEAD,
      S_HEADW,
      S_NODE,
      S_ACT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = stat.op_valid ? S_HEADW : S_ACT;
         end
         S_HEADW: begin
            cmd.head_chk = 1'b1;
            state_in     = stat.head_valid ? S_NODE : S_ACT;
         end
         S_NODE: begin
            cmd.node_chk = 1'b1;
            if (stat.key_match || !stat.link_valid) state_in = S_ACT;
         end
         S_ACT: begin
            cmd.finish = stat.out_free;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: src/chm_datapath.sv
// ----------------------------------------------------------------------------
// chm_datapath: bucket, node and free stack memories with walk registers
// computes the bucket index, compares keys and builds the response word
// ----------------------------------------------------------------------------
module chm_datapath #(
   parameter int TABLE_ORDER = 10,
   parameter int NODE_COUNT  = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chm_pkg::chm_cmd_type  cmd,
   output chm_pkg::chm_stat_type stat,
   input  logic [1:0]            req_operation,
   input  logic signed [31:0]    req_key,
   input  logic [31:0]           req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [31:0]           rsp_value_out,
   output logic                  rsp_status
);
   import chm_pkg::*;

   localparam int BUCKETS = 1 << TABLE_ORDER;
   localparam int NW      = $clog2(NODE_COUNT);
   localparam int FCW     = $clog2(NODE_COUNT + 1);
   localparam int MAXN    = (BUCKETS > NODE_COUNT) ? BUCKETS : NODE_COUNT;
   localparam int CW      = $clog2(MAXN);
   localparam int HW      = NW + 1;
   localparam int NRW     = NW + 65;

   // request, walk, free stack, clearing and response registers
   op_type                   op_ff;
   logic [31:0]              key_ff;
   logic [31:0]              val_ff;
   logic [TABLE_ORDER-1:0]   bkt_ff;
   logic                     hit_ff;
   logic [NW-1:0]            cur_ff;
   logic [NW-1:0]            prev_ff;
   logic                     has_prev_ff;
   logic [31:0]              prev_key_ff;
   logic [31:0]              prev_val_ff;
   logic [FCW-1:0]           free_cnt_ff;
   logic [CW-1:0]            clr_cnt_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [31:0]              rsp_value_ff;
   logic                     rsp_status_ff;

   logic [31:0]              hash_word;
   logic [FCW-1:0]           free_dec;

   // memory ports
   logic                     h_we, n_we, f_we, n_re;
   logic [TABLE_ORDER-1:0]   h_waddr;
   logic [HW-1:0]            h_wdata, h_rdata;
   logic [NW-1:0]            n_waddr, n_raddr, f_waddr, f_raddr;
   logic [NRW-1:0]           n_wdata, n_rdata;
   logic [NW-1:0]            f_wdata, f_rdata;

   // node record fields
   logic                     n_lv;
   logic [NW-1:0]            n_link;
   logic [31:0]              n_key, n_val;

   assign n_lv   = n_rdata[NRW-1];
   assign n_link = n_rdata[NW+63:64];
   assign n_key  = n_rdata[63:32];
   assign n_val  = n_rdata[31:0];

   assign hash_word = req_key ^ (req_key >>> TABLE_ORDER);
   assign free_dec  = free_cnt_ff - FCW'(1);
   assign f_raddr   = free_dec[NW-1:0];

   always_comb begin
      stat.clr_done   = (clr_cnt_ff == CW'(MAXN - 1));
      stat.op_valid   = (op_ff != OP_UNUSED);
      stat.head_valid = h_rdata[NW];
      stat.key_match  = (n_key == key_ff);
      stat.link_valid = n_lv;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // node read address: head index first, then the chain link
   always_comb begin
      n_re    = 1'b0;
      n_raddr = h_rdata[NW-1:0];
      if (cmd.head_chk) begin
         n_re = h_rdata[NW];
      end else if (cmd.node_chk) begin
         n_re    = !stat.key_match && n_lv;
         n_raddr = n_link;
      end
   end

   // memory writes: clearing pass or the final update
   always_comb begin
      h_we    = 1'b0;
      h_waddr = bkt_ff;
      h_wdata = '0;
      n_we    = 1'b0;
      n_waddr = cur_ff;
      n_wdata = n_rdata;
      f_we    = 1'b0;
      f_waddr = free_cnt_ff[NW-1:0];
      f_wdata = cur_ff;
      if (cmd.clr_step) begin
         h_we    = ({1'b0, clr_cnt_ff} < (CW + 1)'(BUCKETS));
         h_waddr = clr_cnt_ff[TABLE_ORDER-1:0];
         f_we    = ({1'b0, clr_cnt_ff} < (CW + 1)'(NODE_COUNT));
         f_waddr = clr_cnt_ff[NW-1:0];
         f_wdata = clr_cnt_ff[NW-1:0];
      end else if (cmd.finish) begin
         unique case (op_ff)
            OP_INSERT: begin
               if (hit_ff) begin
                  n_we    = 1'b1;
                  n_wdata = {n_lv, n_link, n_key, val_ff};
               end else if (free_cnt_ff != '0) begin
                  n_we    = 1'b1;
                  n_waddr = f_rdata;
                  n_wdata = {h_rdata, key_ff, val_ff};
                  h_we    = 1'b1;
                  h_wdata = {1'b1, f_rdata};
               end
            end
            OP_REMOVE: begin
               if (hit_ff) begin
                  if (has_prev_ff) begin
                     n_we    = 1'b1;
                     n_waddr = prev_ff;
                     n_wdata = {n_lv, n_link, prev_key_ff, prev_val_ff};
                  end else begin
                     h_we    = 1'b1;
                     h_wdata = {n_lv, n_link};
                  end
                  f_we = (free_cnt_ff < FCW'(NODE_COUNT));
               end
            end
            OP_LOOKUP, OP_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_operation);
         key_ff <= req_key;
         val_ff <= req_value;
         bkt_ff <= hash_word[TABLE_ORDER-1:0];
      end
      if (cmd.head_chk) begin
         cur_ff <= h_rdata[NW-1:0];
      end
      if (cmd.node_chk && !stat.key_match) begin
         prev_ff     <= cur_ff;
         prev_key_ff <= n_key;
         prev_val_ff <= n_val;
         cur_ff      <= n_link;
      end
      if (cmd.finish) begin
         rsp_found_ff  <= hit_ff;
         rsp_value_ff  <= (op_ff == OP_LOOKUP && hit_ff) ? n_val : 32'd0;
         rsp_status_ff <= (op_ff == OP_INSERT) && !hit_ff && (free_cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         has_prev_ff  <= 1'b0;
         free_cnt_ff  <= FCW'(NODE_COUNT);
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + CW'(1);
         if (cmd.accept) begin
            hit_ff      <= 1'b0;
            has_prev_ff <= 1'b0;
         end
         if (cmd.node_chk) begin
            if (stat.key_match) hit_ff <= 1'b1;
            else has_prev_ff <= 1'b1;
         end
         if (cmd.finish) begin
            if (op_ff == OP_INSERT && !hit_ff && free_cnt_ff != '0) begin
               free_cnt_ff <= free_dec;
            end else if (op_ff == OP_REMOVE && hit_ff && free_cnt_ff < FCW'(NODE_COUNT)) begin
               free_cnt_ff <= free_cnt_ff + FCW'(1);
            end
         end
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   chm_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_head_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .re    (cmd.head_rd),
      .raddr (bkt_ff),
      .rdata (h_rdata)
   );

   chm_ram #(.WIDTH(NRW), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock (clock),
      .we    (n_we),
      .waddr (n_waddr),
      .wdata (n_wdata),
      .re    (n_re),
      .raddr (n_raddr),
      .rdata (n_rdata)
   );

   chm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_free_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .re    (cmd.head_rd),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// File: src/chained_hash_map_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_map_engine_unit: key to value map with chained buckets
// a request goes through the bucket head read, the chain walk over its bucket's nodes
// (none on an empty bucket; head check and walk skipped for the unused code) and the
// final update; one request at a time, a new one is taken only back in idle
// after reset a clearing pass empties the buckets and refills the free stack;
// req ready stays low meanwhile
// ----------------------------------------------------------------------------
module chained_hash_map_engine_unit #(
   parameter int TABLE_ORDER = 10,
   parameter int NODE_COUNT  = 1024
) (
   input logic     clock,
   input logic     reset,
   chm_req_if.sink   req_ch,
   chm_rsp_if.source rsp_ch
);
   import chm_pkg::*;

   // command and status between the sequencer and the datapath
   chm_cmd_type  cmd;
   chm_stat_type stat;

   // sequencer: clear, head read, chain walk, update
   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ch.ready)
   );

   // datapath: memories, walk registers and response register
   chm_datapath #(
      .TABLE_ORDER (TABLE_ORDER),
      .NODE_COUNT  (NODE_COUNT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_ch.operation),
      .req_key       (req_ch.key),
      .req_value     (req_ch.value),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_found     (rsp_ch.found),
      .rsp_value_out (rsp_ch.value_out),
      .rsp_status    (rsp_ch.status)
   );

endmodule

// File: src/chm_checker.sv
// ----------------------------------------------------------------------------
// chm_checker: port level checks of the hash map engine
// bound to the top level
// ----------------------------------------------------------------------------
module chm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_value_out,
   input logic        rsp_status
);

   // response word held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_value_out)
                                  && $stable(rsp_status))
      else $error("response word changed while stalled");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // nothing comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("handshake active right after reset");

   // a miss or drop never reports a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_found || rsp_status) |-> rsp_value_out == 32'd0)
      else $error("value reported without a hit");

endmodule

bind chained_hash_map_engine_unit chm_checker u_chm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_found     (rsp_ch.found),
   .rsp_value_out (rsp_ch.value_out),
   .rsp_status    (rsp_ch.status)
);
